FILE: hdl/dva_pkg.sv
// Package for the distance volume attenuation block.
// Holds the bypass code type and the register map of the configuration port.
// No dependencies.
package dva_pkg;

    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_FULL_GAIN        = 2'd0;
    localparam reg_idx_t REG_MIN_DISTANCE     = 2'd1;
    localparam reg_idx_t REG_MAX_DISTANCE     = 2'd2;
    localparam reg_idx_t REG_HALVING_DISTANCE = 2'd3;

    // Items that skip the arithmetic carry one of these codes down the pipe.
    typedef enum logic [1:0] {
        BYP_NONE,
        BYP_ZERO,
        BYP_FULL
    } byp_t;

endpackage

FILE: hdl/distance_volume_attenuation.sv
// Top level of the distance volume attenuation block: APB register file and
// a fully pipelined datapath of two restoring dividers around one multiplier.
// Depends on dva_pkg.

// Maps a distance beat to a Q1.15 volume beat. The pipeline takes one beat per
// cycle while the volume side does not stall; its depth comes mostly from the
// two pipelined dividers, one stage per quotient bit (DIST_WIDTH stages for the
// halving count, one stage per gain bit for the final scaling). All stages
// advance together, so a stall on the volume side holds the whole pipe.
// Registers sit at byte addresses 0 (full_gain), 4 (min_distance),
// 8 (max_distance) and 12 (halving_distance) and may only be written while
// no beat is in flight. A halving distance of zero behaves as one.
module distance_volume_attenuation #(
    parameter int DIST_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 15
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [dva_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [dva_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [dva_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready,
    input  logic                                distance_valid,
    output logic                                distance_ready,
    input  logic [DIST_WIDTH-1:0]               distance,
    output logic                                volume_valid,
    input  logic                                volume_ready,
    output logic [GAIN_FRAC_BITS:0]             volume
);

    import dva_pkg::*;

    localparam int GAIN_BITS = GAIN_FRAC_BITS + 1;
    localparam int SHW       = $clog2(GAIN_BITS);
    localparam int PW        = GAIN_BITS + DIST_WIDTH + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [GAIN_BITS-1:0]  full_gain_reg;
    logic [DIST_WIDTH-1:0] min_distance_reg;
    logic [DIST_WIDTH-1:0] max_distance_reg;
    logic [DIST_WIDTH-1:0] halving_distance_reg;
    logic                  cfg_write;
    reg_idx_t              cfg_idx;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[APB_ADDR_WIDTH-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_gain_reg        <= GAIN_BITS'(1) << GAIN_FRAC_BITS;
            min_distance_reg     <= '0;
            max_distance_reg     <= '1;
            halving_distance_reg <= DIST_WIDTH'(256);
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_FULL_GAIN:        full_gain_reg        <= pwdata[GAIN_BITS-1:0];
                REG_MIN_DISTANCE:     min_distance_reg     <= pwdata[DIST_WIDTH-1:0];
                REG_MAX_DISTANCE:     max_distance_reg     <= pwdata[DIST_WIDTH-1:0];
                REG_HALVING_DISTANCE: halving_distance_reg <= pwdata[DIST_WIDTH-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FULL_GAIN:        prdata = APB_DATA_WIDTH'(full_gain_reg);
            REG_MIN_DISTANCE:     prdata = APB_DATA_WIDTH'(min_distance_reg);
            REG_MAX_DISTANCE:     prdata = APB_DATA_WIDTH'(max_distance_reg);
            REG_HALVING_DISTANCE: prdata = APB_DATA_WIDTH'(halving_distance_reg);
            default:              prdata = '0;
        endcase
    end

    logic [DIST_WIDTH-1:0] s_eff;
    logic [DIST_WIDTH+1:0] s2_ext;

    assign s_eff  = (halving_distance_reg == '0) ? DIST_WIDTH'(1) : halving_distance_reg;
    assign s2_ext = {1'b0, s_eff, 1'b0};

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves when the output register frees up.
    // ------------------------------------------------------------------
    logic adv;
    logic out_valid_reg;

    assign adv            = !out_valid_reg || volume_ready;
    assign distance_ready = adv;

    // ------------------------------------------------------------------
    // Entry: range checks and offset from the minimum distance
    // ------------------------------------------------------------------
    byp_t                  byp0;
    logic [DIST_WIDTH-1:0] d0;

    always_comb
    begin
        d0 = distance - min_distance_reg;
        priority if (distance >= max_distance_reg)
            byp0 = BYP_ZERO;
        else if (distance <= min_distance_reg)
            byp0 = BYP_FULL;
        else
            byp0 = BYP_NONE;
    end

    // ------------------------------------------------------------------
    // Divider 1: d / S, one quotient bit per stage
    // ------------------------------------------------------------------
    logic                  v1_reg    [0:DIST_WIDTH];
    byp_t                  byp1_reg  [0:DIST_WIDTH];
    logic [DIST_WIDTH-1:0] rem1_reg  [0:DIST_WIDTH];
    logic [DIST_WIDTH-1:0] numq1_reg [0:DIST_WIDTH];
    logic [DIST_WIDTH-1:0] rem1_next [1:DIST_WIDTH];
    logic [DIST_WIDTH-1:0] numq1_next[1:DIST_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg[0] <= 1'b0;
        else if (adv)
            v1_reg[0] <= distance_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp1_reg[0]  <= byp0;
            rem1_reg[0]  <= '0;
            numq1_reg[0] <= d0;
        end
    end

    genvar j;
    generate
        for (j = 0; j < DIST_WIDTH; j++)
        begin : g_div1
            logic [DIST_WIDTH:0] t1;
            logic [DIST_WIDTH:0] diff1;
            logic                ge1;

            assign t1    = {rem1_reg[j], numq1_reg[j][DIST_WIDTH-1]};
            assign diff1 = t1 - {1'b0, s_eff};
            assign ge1   = t1 >= {1'b0, s_eff};

            assign rem1_next[j+1]  = ge1 ? diff1[DIST_WIDTH-1:0] : t1[DIST_WIDTH-1:0];
            assign numq1_next[j+1] = {numq1_reg[j][DIST_WIDTH-2:0], ge1};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v1_reg[j+1] <= 1'b0;
                else if (adv)
                    v1_reg[j+1] <= v1_reg[j];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    byp1_reg[j+1]  <= byp1_reg[j];
                    rem1_reg[j+1]  <= rem1_next[j+1];
                    numq1_reg[j+1] <= numq1_next[j+1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Fix-up: an exact multiple counts one halving fewer with r = S.
    // ------------------------------------------------------------------
    logic [DIST_WIDTH-1:0] q1;
    logic [DIST_WIDTH-1:0] r1;
    logic [DIST_WIDTH-1:0] qf;
    logic [DIST_WIDTH-1:0] rf;
    byp_t                  bypf_next;
    logic [GAIN_BITS-1:0]  gf_next;
    logic [DIST_WIDTH:0]   mf_next;

    logic                  vf_reg;
    byp_t                  bypf_reg;
    logic [GAIN_BITS-1:0]  gf_reg;
    logic [DIST_WIDTH:0]   mf_reg;

    always_comb
    begin
        q1 = numq1_reg[DIST_WIDTH];
        r1 = rem1_reg[DIST_WIDTH];
        if (r1 == '0)
        begin
            qf = q1 - DIST_WIDTH'(1);
            rf = s_eff;
        end
        else
        begin
            qf = q1;
            rf = r1;
        end
        if (byp1_reg[DIST_WIDTH] == BYP_NONE && qf >= DIST_WIDTH'(GAIN_BITS))
            bypf_next = BYP_ZERO;
        else
            bypf_next = byp1_reg[DIST_WIDTH];
        gf_next = full_gain_reg >> qf[SHW-1:0];
        mf_next = {s_eff, 1'b0} - {1'b0, rf};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (adv)
            vf_reg <= v1_reg[DIST_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bypf_reg <= bypf_next;
            gf_reg   <= gf_next;
            mf_reg   <= mf_next;
        end
    end

    // ------------------------------------------------------------------
    // Multiply g * (2S - r); the product seeds divider 2.
    // ------------------------------------------------------------------
    logic [PW-1:0] prod;

    assign prod = PW'(gf_reg) * PW'(mf_reg);

    // ------------------------------------------------------------------
    // Divider 2: product / 2S. The quotient is below g, so GAIN_BITS stages.
    // ------------------------------------------------------------------
    logic                  v2_reg    [0:GAIN_BITS];
    byp_t                  byp2_reg  [0:GAIN_BITS];
    logic [DIST_WIDTH:0]   rem2_reg  [0:GAIN_BITS];
    logic [GAIN_BITS-1:0]  numq2_reg [0:GAIN_BITS];
    logic [DIST_WIDTH:0]   rem2_next [1:GAIN_BITS];
    logic [GAIN_BITS-1:0]  numq2_next[1:GAIN_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg[0] <= 1'b0;
        else if (adv)
            v2_reg[0] <= vf_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp2_reg[0]  <= bypf_reg;
            rem2_reg[0]  <= prod[PW-1:GAIN_BITS];
            numq2_reg[0] <= prod[GAIN_BITS-1:0];
        end
    end

    genvar k;
    generate
        for (k = 0; k < GAIN_BITS; k++)
        begin : g_div2
            logic [DIST_WIDTH+1:0] t2;
            logic [DIST_WIDTH+1:0] diff2;
            logic                  ge2;

            assign t2    = {rem2_reg[k], numq2_reg[k][GAIN_BITS-1]};
            assign diff2 = t2 - s2_ext;
            assign ge2   = t2 >= s2_ext;

            assign rem2_next[k+1]  = ge2 ? diff2[DIST_WIDTH:0] : t2[DIST_WIDTH:0];
            assign numq2_next[k+1] = {numq2_reg[k][GAIN_BITS-2:0], ge2};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v2_reg[k+1] <= 1'b0;
                else if (adv)
                    v2_reg[k+1] <= v2_reg[k];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    byp2_reg[k+1]  <= byp2_reg[k];
                    rem2_reg[k+1]  <= rem2_next[k+1];
                    numq2_reg[k+1] <= numq2_next[k+1];
                end
            end
        end
    endgenerate

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [GAIN_BITS-1:0] volume_next;
    logic [GAIN_BITS-1:0] volume_reg;

    always_comb
    begin
        unique case (byp2_reg[GAIN_BITS])
            BYP_NONE: volume_next = numq2_reg[GAIN_BITS];
            BYP_FULL: volume_next = full_gain_reg;
            default:  volume_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= v2_reg[GAIN_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            volume_reg <= volume_next;
    end

    assign volume_valid = out_valid_reg;
    assign volume       = volume_reg;

`ifndef SYNTHESIS
    // The first divider always leaves a remainder below the divisor.
    a_div1_rem: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg[DIST_WIDTH] |-> rem1_reg[DIST_WIDTH] < s_eff)
        else $error("halving divider remainder out of range");

    // The product's upper part must start below 2S, or the quotient overflows.
    a_div2_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg[0] && byp2_reg[0] == BYP_NONE) |-> {1'b0, rem2_reg[0]} < s2_ext)
        else $error("scaling divider seeded above its divisor");

    // Attenuation never raises the volume above the full gain.
    a_vol_bound: assert property (@(posedge clk) disable iff (!rst_n)
        volume_valid |-> volume <= full_gain_reg)
        else $error("volume above full gain");
`endif

endmodule
